// File: src/spq_pkg.sv
package spq_pkg;

  // Defaults for the top-level parameters
  localparam int LEVELS_DEF      = 10;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // Fixed field widths of the item channels
  localparam int PRIO_W    = 4;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 3;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_PRIO = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Per-level flags reported by each cell
  typedef struct packed {
    logic full;      // level holds LEVEL_DEPTH items
    logic sel;       // highest non-empty level, wins a dequeue
  } cell_stat_t;

endpackage

// File: src/spq_in_if.sv
interface spq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [spq_pkg::PRIO_W-1:0]   priority_req;
  logic [spq_pkg::PAYLOAD_W-1:0] payload;

  modport source (output valid, operation, priority_req, payload, input ready);
  modport sink   (input valid, operation, priority_req, payload, output ready);
endinterface

// File: src/spq_out_if.sv
interface spq_out_if;
  logic                          valid;
  logic                          ready;
  spq_pkg::status_t              status;
  logic [spq_pkg::PAYLOAD_W-1:0] out_payload;
  logic [spq_pkg::PRIO_W-1:0]    out_priority;

  modport source (output valid, status, out_payload, out_priority, input ready);
  modport sink   (input valid, status, out_payload, out_priority, output ready);
endinterface

// File: src/spq_ram.sv
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/spq_cell.sv
module spq_cell #(
  parameter int LEVEL_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           enq_en,
  input  logic                           deq_en,
  input  logic                           higher_in,
  output logic                           higher_out,
  output spq_pkg::cell_stat_t            stat,
  output logic [$clog2(LEVEL_DEPTH)-1:0] head,
  output logic [$clog2(LEVEL_DEPTH)-1:0] tail
);
  import spq_pkg::*;

  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LEVEL_DEPTH);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             nonempty;
  logic             do_enq;
  logic             do_deq;

  assign nonempty   = (cnt_r != '0);
  assign higher_out = higher_in | nonempty;
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.sel   = nonempty & ~higher_in;
  assign head       = head_r;
  assign tail       = tail_r;

  assign do_enq = enq_en & ~stat.full;
  assign do_deq = deq_en & stat.sel;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (do_enq) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end else if (do_deq) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: src/strict_priority_fifo_queue_core.sv
// Strict-priority queue core: LEVELS FIFO levels in one shared payload RAM.
// Enqueue and rejected items give their result in the result register the cycle after accept;
// a dequeue that finds an item goes through the registered RAM read, then the result register.
// Throughput: 1 item per cycle while the output is taken; after a successful dequeue no new
// item is accepted while the payload RAM read is pending.
// Reset: rst_n synchronous, active low; clears all level pointers and counts.
module strict_priority_fifo_queue_core #(
  parameter int LEVELS      = spq_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = spq_pkg::LEVEL_DEPTH_DEF,
  parameter int DATA_WIDTH  = spq_pkg::DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);
  import spq_pkg::*;

  localparam int PTR_W   = $clog2(LEVEL_DEPTH);
  localparam int LVL_W   = $clog2(LEVELS);
  localparam int ADDR_W  = LVL_W + PTR_W;
  localparam int RAM_D   = LEVELS << PTR_W;
  // Only the low bits of the payload field can ever be stored
  localparam int STORE_W = (DATA_WIDTH < PAYLOAD_W) ? DATA_WIDTH : PAYLOAD_W;

  // ---------------------------------------------------------------------------
  // Chain of level cells. The "higher level non-empty" flag ripples from the
  // top level down; the first non-empty cell raises sel and owns the dequeue.
  // ---------------------------------------------------------------------------
  logic             chain   [LEVELS+1];
  cell_stat_t       stat_v  [LEVELS];
  logic [PTR_W-1:0] heads   [LEVELS];
  logic [PTR_W-1:0] tails   [LEVELS];
  logic [LEVELS-1:0] sel_v;
  logic [LEVELS-1:0] full_v;

  logic             acc;
  logic             is_deq;
  logic             prio_ok;
  logic [LVL_W-1:0] lvl;
  logic             lvl_full;
  logic             enq_go;
  logic             deq_go;
  logic             any_ne;
  logic [LVL_W-1:0] deq_lvl;
  logic [PTR_W-1:0] deq_head;

  assign chain[LEVELS] = 1'b0;  // nothing above the top level

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    spq_cell #(
      .LEVEL_DEPTH (LEVEL_DEPTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .enq_en     (enq_go && (in_if.priority_req == PRIO_W'(i))),
      .deq_en     (deq_go),
      .higher_in  (chain[i+1]),
      .higher_out (chain[i]),
      .stat       (stat_v[i]),
      .head       (heads[i]),
      .tail       (tails[i])
    );
    assign sel_v[i]  = stat_v[i].sel;
    assign full_v[i] = stat_v[i].full;
  end

  assign any_ne = chain[0];

  // sel_v is one-hot when any level holds an item: encode it and pick its head
  always_comb begin
    deq_lvl  = '0;
    deq_head = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (sel_v[i]) begin
        deq_lvl  = deq_lvl | LVL_W'(i);
        deq_head = deq_head | heads[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic rd_pend_r, rd_pend_nxt;
  logic out_valid_r, out_valid_nxt;

  // A new item needs a free result register; none while a RAM read is pending
  assign in_if.ready = ~rd_pend_r & (~out_valid_r | out_if.ready);
  assign acc         = in_if.valid & in_if.ready;
  assign is_deq      = (in_if.operation == OP_DEQ);
  assign prio_ok     = ({1'b0, in_if.priority_req} < (PRIO_W + 1)'(LEVELS));
  assign lvl         = in_if.priority_req[LVL_W-1:0];
  assign lvl_full    = prio_ok ? full_v[lvl] : 1'b0;
  assign enq_go      = acc & ~is_deq & prio_ok & ~lvl_full;
  assign deq_go      = acc & is_deq & any_ne;

  // ---------------------------------------------------------------------------
  // Shared payload RAM: address is {level, slot}
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [STORE_W-1:0] rdata;

  assign waddr = {lvl, tails[lvl]};
  assign raddr = {deq_lvl, deq_head};

  spq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk   (clk),
    .we    (enq_go),
    .waddr (waddr),
    .wdata (in_if.payload[STORE_W-1:0]),
    .re    (deq_go),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  status_t              status_r, status_nxt;
  logic [PAYLOAD_W-1:0] pay_r, pay_nxt;
  logic [PRIO_W-1:0]    prio_r, prio_nxt;
  logic [LVL_W-1:0]     rd_lvl_r;

  always_comb begin
    rd_pend_nxt   = deq_go;
    out_valid_nxt = out_valid_r & ~out_if.ready;
    status_nxt    = status_r;
    pay_nxt       = pay_r;
    prio_nxt      = prio_r;
    priority if (rd_pend_r) begin
      // read data lands now; the result register was freed at accept time
      out_valid_nxt = 1'b1;
      status_nxt    = ST_DEQUEUED;
      pay_nxt       = PAYLOAD_W'(rdata);
      prio_nxt      = PRIO_W'(rd_lvl_r);
    end else if (acc && !deq_go) begin
      out_valid_nxt = 1'b1;
      pay_nxt       = '0;
      prio_nxt      = '0;
      priority if (is_deq) begin
        status_nxt = ST_EMPTY;
      end else if (!prio_ok) begin
        status_nxt = ST_BAD_PRIO;
      end else if (lvl_full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_ENQUEUED;
      end
    end else begin
      // nothing new: result register holds until taken
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pay_r    <= pay_nxt;
    prio_r   <= prio_nxt;
    if (deq_go) begin
      rd_lvl_r <= deq_lvl;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = status_r;
  assign out_if.out_payload  = pay_r;
  assign out_if.out_priority = prio_r;

`ifndef SYNTHESIS
  // a pending RAM read always turns into a result on the next cycle
  a_rd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> (out_if.valid && out_if.status == ST_DEQUEUED))
    else $error("pending read did not produce a dequeued result");

  // no new item while the RAM read port is busy
  a_no_acc_rd: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !in_if.ready)
    else $error("item accepted during pending read");

  // at most one level owns a dequeue, and it exists exactly when any level is non-empty
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_v) && ((sel_v != '0) == any_ne))
    else $error("dequeue level select not one-hot");

  // only a dequeued result carries data or a level number
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.status != ST_DEQUEUED) |->
      (out_if.out_payload == '0 && out_if.out_priority == '0))
    else $error("non-dequeue result carries payload");
`endif

endmodule
